// File: hw/rtl/psdmb_pkg.sv
// shared types and constants for the pauli sum dense matrix builder
`timescale 1ns / 1ps
package psdmb_pkg;

  localparam int MAX_QUBITS = 5;
  localparam int IDX_W      = MAX_QUBITS;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int PART_W     = 32;
  localparam int ENTRY_W    = 2 * PART_W;
  localparam int COEFF_W    = 24;
  localparam int QC_W       = 3;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [QC_W-1:0] QC_RESET = QC_W'(5);

  // register index, taken from the word address bit of paddr
  localparam logic [0:0] REG_QUBIT_COUNT = 1'b0;

  localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

  localparam logic signed [PART_W-1:0] PART_MAX = {1'b0, {(PART_W-1){1'b1}}};
  localparam logic signed [PART_W-1:0] PART_MIN = {1'b1, {(PART_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_FLUSH,
    S_READ,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/psdmb_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module psdmb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/pauli_sum_dense_matrix_builder.sv
// top level: dense matrix builder for a weighted sum of pauli strings
//
//  channel | direction | handshake                     | payload
//  cfg     | in/out    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//  in      | in        | in_valid, in_ready            | op, x_mask, z_mask, coeff, row, col
//  out     | out       | out_valid, out_ready          | real_part, imag_part, status
//
// accumulate with nonzero coefficient: one read-modify-write of the matrix ram
// per column, read and write overlapped; clear: one ram entry per cycle.
// after reset a clearing pass over all 1024 entries runs with in_ready low.
// one request is in flight at a time; the output register holds a result
// while the next request is accepted, and a stalled result holds the fsm.
`timescale 1ns / 1ps
module pauli_sum_dense_matrix_builder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [psdmb_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [psdmb_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [psdmb_pkg::PDATA_W-1:0]        cfg_prdata,
  output logic                                 cfg_pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [psdmb_pkg::OP_W-1:0]           in_op,
  input  logic [psdmb_pkg::IDX_W-1:0]          in_x_mask,
  input  logic [psdmb_pkg::IDX_W-1:0]          in_z_mask,
  input  logic signed [psdmb_pkg::COEFF_W-1:0] in_coeff,
  input  logic [psdmb_pkg::IDX_W-1:0]          in_row_index,
  input  logic [psdmb_pkg::IDX_W-1:0]          in_col_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [psdmb_pkg::PART_W-1:0]  out_real_part,
  output logic signed [psdmb_pkg::PART_W-1:0]  out_imag_part,
  output logic [psdmb_pkg::STATUS_W-1:0]       out_status
);

  localparam int EXT_W = psdmb_pkg::PART_W + 1;

  psdmb_pkg::state_t state_r, state_nxt;

  logic [psdmb_pkg::QC_W-1:0]    qubit_count_r;
  logic [psdmb_pkg::QC_W-1:0]    n_act;
  logic [psdmb_pkg::IDX_W-1:0]   dim_mask;

  logic [psdmb_pkg::ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic                          clr_item_r;
  logic [psdmb_pkg::IDX_W-1:0]   col_r, col_nxt;
  logic                          pend_r;
  logic [psdmb_pkg::IDX_W-1:0]   pend_col_r;
  logic                          sat_r, sat_nxt;

  logic [psdmb_pkg::OP_W-1:0]    op_r;
  logic [psdmb_pkg::IDX_W-1:0]   xm_r;
  logic [psdmb_pkg::IDX_W-1:0]   zm_r;
  logic signed [psdmb_pkg::COEFF_W-1:0] coeff_r;
  logic [1:0]                    base_r;
  logic [psdmb_pkg::IDX_W-1:0]   row_r;
  logic [psdmb_pkg::IDX_W-1:0]   rcol_r;
  logic                          oob_r;

  logic                          out_valid_r;
  logic signed [psdmb_pkg::PART_W-1:0] out_real_r;
  logic signed [psdmb_pkg::PART_W-1:0] out_imag_r;
  logic [psdmb_pkg::STATUS_W-1:0] out_status_r;

  logic                          in_acc;
  logic                          out_load;
  logic                          cfg_wr;
  logic [psdmb_pkg::IDX_W-1:0]   in_xm;
  logic [psdmb_pkg::IDX_W-1:0]   in_zm;

  logic                          ram_we;
  logic [psdmb_pkg::ADDR_W-1:0]  ram_waddr;
  logic [psdmb_pkg::ENTRY_W-1:0] ram_wdata;
  logic                          ram_re;
  logic [psdmb_pkg::ADDR_W-1:0]  ram_raddr;
  logic [psdmb_pkg::ENTRY_W-1:0] ram_rdata;

  logic                          upd_neg;
  logic                          upd_im;
  logic signed [psdmb_pkg::PART_W-1:0] old_part;
  logic signed [psdmb_pkg::PART_W-1:0] new_part;
  logic signed [EXT_W-1:0]       delta;
  logic signed [EXT_W-1:0]       sum;
  logic                          upd_sat;
  logic [psdmb_pkg::ENTRY_W-1:0] upd_data;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite &
                  (cfg_paddr[2:2] == psdmb_pkg::REG_QUBIT_COUNT);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:2] == psdmb_pkg::REG_QUBIT_COUNT) begin
      cfg_prdata = psdmb_pkg::PDATA_W'(qubit_count_r);
    end
  end

  // qubit counts above the maximum act as the maximum
  assign n_act = (qubit_count_r > psdmb_pkg::QC_W'(psdmb_pkg::MAX_QUBITS)) ?
                 psdmb_pkg::QC_W'(psdmb_pkg::MAX_QUBITS) : qubit_count_r;
  assign dim_mask = psdmb_pkg::IDX_W'((32'd1 << n_act) - 32'd1);

  assign in_acc = in_valid & in_ready;
  assign in_xm  = in_x_mask & dim_mask;
  assign in_zm  = in_z_mask & dim_mask;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psdmb_pkg::S_CLEAR: begin
        if (&clr_cnt_r) begin
          state_nxt = clr_item_r ? psdmb_pkg::S_DONE : psdmb_pkg::S_IDLE;
        end
      end
      psdmb_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            psdmb_pkg::OP_ACC: begin
              state_nxt = (in_coeff != '0) ? psdmb_pkg::S_ACC : psdmb_pkg::S_DONE;
            end
            psdmb_pkg::OP_READ:  state_nxt = psdmb_pkg::S_READ;
            psdmb_pkg::OP_CLEAR: state_nxt = psdmb_pkg::S_CLEAR;
            default:             state_nxt = psdmb_pkg::S_DONE;
          endcase
        end
      end
      psdmb_pkg::S_ACC: begin
        if (col_r == dim_mask) begin
          state_nxt = psdmb_pkg::S_FLUSH;
        end
      end
      psdmb_pkg::S_FLUSH: state_nxt = psdmb_pkg::S_DONE;
      psdmb_pkg::S_READ:  state_nxt = psdmb_pkg::S_DONE;
      psdmb_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = psdmb_pkg::S_IDLE;
        end
      end
      default: state_nxt = psdmb_pkg::S_IDLE;
    endcase
  end

  // fsm outputs: handshake, ram ports, counters
  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = {row_r, rcol_r};
    ram_we      = pend_r;
    ram_waddr   = {pend_col_r ^ xm_r, pend_col_r};
    ram_wdata   = upd_data;
    clr_cnt_nxt = '0;
    col_nxt     = col_r;
    unique case (state_r)
      psdmb_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      psdmb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        col_nxt  = '0;
      end
      psdmb_pkg::S_ACC: begin
        // row of column c is c xor x mask
        ram_re    = 1'b1;
        ram_raddr = {col_r ^ xm_r, col_r};
        col_nxt   = col_r + 1'b1;
      end
      psdmb_pkg::S_FLUSH: begin
      end
      psdmb_pkg::S_READ: begin
        ram_re = 1'b1;
      end
      psdmb_pkg::S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // entry update: phase picks the part; phase and z parity of the column pick the sign
  always_comb begin
    upd_im   = base_r[0];
    upd_neg  = base_r[1] ^ (^(pend_col_r & zm_r));
    old_part = upd_im ? ram_rdata[psdmb_pkg::PART_W-1:0] :
                        ram_rdata[psdmb_pkg::ENTRY_W-1:psdmb_pkg::PART_W];
    delta    = {{(EXT_W-psdmb_pkg::COEFF_W){coeff_r[psdmb_pkg::COEFF_W-1]}}, coeff_r};
    if (upd_neg) begin
      delta = -delta;
    end
    sum     = {old_part[psdmb_pkg::PART_W-1], old_part} + delta;
    upd_sat = sum[EXT_W-1] ^ sum[EXT_W-2];
    if (upd_sat) begin
      new_part = sum[EXT_W-1] ? psdmb_pkg::PART_MIN : psdmb_pkg::PART_MAX;
    end else begin
      new_part = sum[psdmb_pkg::PART_W-1:0];
    end
    if (upd_im) begin
      upd_data = {ram_rdata[psdmb_pkg::ENTRY_W-1:psdmb_pkg::PART_W], new_part};
    end else begin
      upd_data = {new_part, ram_rdata[psdmb_pkg::PART_W-1:0]};
    end
    sat_nxt = sat_r | (pend_r & upd_sat);
    if (in_acc) begin
      sat_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= psdmb_pkg::S_CLEAR;
      qubit_count_r <= psdmb_pkg::QC_RESET;
      clr_cnt_r     <= '0;
      clr_item_r    <= 1'b0;
      col_r         <= '0;
      pend_r        <= 1'b0;
      sat_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      col_r     <= col_nxt;
      pend_r    <= (state_r == psdmb_pkg::S_ACC);
      sat_r     <= sat_nxt;
      if (cfg_wr) begin
        qubit_count_r <= cfg_pwdata[psdmb_pkg::QC_W-1:0];
      end
      if (in_acc) begin
        clr_item_r <= (in_op == psdmb_pkg::OP_CLEAR);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_col_r <= col_r;
    if (in_acc) begin
      op_r    <= in_op;
      xm_r    <= in_xm;
      zm_r    <= in_zm;
      coeff_r <= in_coeff;
      base_r  <= 2'($countones(in_xm & in_zm));
      row_r   <= in_row_index;
      rcol_r  <= in_col_index;
      oob_r   <= (|(in_row_index & ~dim_mask)) | (|(in_col_index & ~dim_mask));
    end
    if (out_load) begin
      out_real_r   <= '0;
      out_imag_r   <= '0;
      out_status_r <= psdmb_pkg::ST_OK;
      if (op_r == psdmb_pkg::OP_READ) begin
        if (oob_r) begin
          out_status_r <= psdmb_pkg::ST_OOB;
        end else begin
          out_real_r <= ram_rdata[psdmb_pkg::ENTRY_W-1:psdmb_pkg::PART_W];
          out_imag_r <= ram_rdata[psdmb_pkg::PART_W-1:0];
        end
      end else if (op_r == psdmb_pkg::OP_ACC && sat_r) begin
        out_status_r <= psdmb_pkg::ST_SAT;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_real_part = out_real_r;
  assign out_imag_part = out_imag_r;
  assign out_status    = out_status_r;

  psdmb_ram #(
    .WIDTH (psdmb_pkg::ENTRY_W),
    .DEPTH (psdmb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: hw/rtl/psdmb_checker.sv
// port level checks for the pauli sum dense matrix builder, bound to the top
`timescale 1ns / 1ps
module psdmb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [psdmb_pkg::PART_W-1:0]  out_real_part,
  input logic signed [psdmb_pkg::PART_W-1:0]  out_imag_part,
  input logic [psdmb_pkg::STATUS_W-1:0]       out_status
);

  // clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("in_ready high during clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // only a good read carries data
  a_no_data_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != psdmb_pkg::ST_OK) |->
      (out_real_part == '0 && out_imag_part == '0 &&
       (out_status == psdmb_pkg::ST_OOB || out_status == psdmb_pkg::ST_SAT)))
    else $error("bad result on flagged status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_real_part) && $stable(out_imag_part) &&
       $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind pauli_sum_dense_matrix_builder psdmb_checker u_psdmb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_real_part (out_real_part),
  .out_imag_part (out_imag_part),
  .out_status    (out_status)
);
